[sv/periodic_sphere_voxelizer_defines.svh]
// assertion macros used by the checker
`ifndef PERIODIC_SPHERE_VOXELIZER_DEFINES_SVH
`define PERIODIC_SPHERE_VOXELIZER_DEFINES_SVH

// same-cycle implication, masked while reset is active
`define PSV_ASSERT_IMP(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error("psv assertion failed");

// next-cycle implication, masked while reset is active
`define PSV_ASSERT_NXT(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error("psv assertion failed");

`endif

[sv/psv_pkg.sv]
`timescale 1ns / 1ps
package psv_pkg;

    localparam int GRID_DIM   = 32;
    localparam int VALUE_BITS = 16;

    // fixed field widths
    localparam int POS_W      = 5;
    localparam int CFG_W      = 6;
    localparam int FILL_W     = 16;
    localparam int OUT_W      = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // derived widths
    localparam int COORD_W     = $clog2(GRID_DIM);
    localparam int ADDR_W      = 3 * COORD_W;
    localparam int STORE_DEPTH = 1 << ADDR_W;
    localparam int DIM_W       = $clog2(GRID_DIM + 1);
    localparam int CNT_W       = $clog2(2 * GRID_DIM + 1);
    localparam int SQ_W        = $clog2(GRID_DIM * GRID_DIM + 1);
    localparam int SUM_W       = $clog2(3 * GRID_DIM * GRID_DIM + 1);
    localparam int WRAP_W      = ((DIM_W > POS_W) ? DIM_W : POS_W) + 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DIM_X  = 3'd0,
        CFG_DIM_Y  = 3'd1,
        CFG_DIM_Z  = 3'd2,
        CFG_RADIUS = 3'd3,
        CFG_FILL   = 3'd4
    } psv_cfg_idx_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_WRAP,
        ST_SWEEP,
        ST_READ,
        ST_DONE
    } psv_state_t;

    typedef enum logic [1:0] {
        AX_X,
        AX_Y,
        AX_Z
    } psv_axis_t;

    typedef enum logic {
        REQ_PLACE = 1'b0,
        REQ_READ  = 1'b1
    } psv_req_t;

    // effective settings seen by the sequencer
    typedef struct packed {
        logic [DIM_W-1:0]      dim_x;
        logic [DIM_W-1:0]      dim_y;
        logic [DIM_W-1:0]      dim_z;
        logic [DIM_W-1:0]      radius;
        logic [VALUE_BITS-1:0] fill;
    } psv_cfg_t;

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [CFG_W-1:0] d);
        if (d == '0)
            return DIM_W'(1);
        else if (int'(d) > GRID_DIM)
            return DIM_W'(GRID_DIM);
        else
            return DIM_W'(d);
    endfunction

    function automatic logic [DIM_W-1:0] clamp_rad(input logic [CFG_W-1:0] r);
        if (int'(r) > GRID_DIM)
            return DIM_W'(GRID_DIM);
        else
            return DIM_W'(r);
    endfunction

    // saturate the q4.12 fill into the signed store width
    function automatic logic [VALUE_BITS-1:0] sat_fill(input logic signed [FILL_W-1:0] f);
        longint hi;
        longint lo;
        longint v;
        hi = (longint'(1) <<< (VALUE_BITS - 1)) - 1;
        lo = -hi - 1;
        v  = longint'(f);
        if (v > hi)
            v = hi;
        if (v < lo)
            v = lo;
        return VALUE_BITS'(v);
    endfunction

    // sign-extend a stored voxel and keep the low output bits
    function automatic logic signed [OUT_W-1:0] widen(input logic [VALUE_BITS-1:0] s);
        longint v;
        v = longint'($signed(s));
        return OUT_W'(v);
    endfunction

endpackage

[sv/psv_cfg_if.sv]
`timescale 1ns / 1ps
interface psv_cfg_if;
    import psv_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

[sv/psv_req_if.sv]
`timescale 1ns / 1ps
interface psv_req_if;
    import psv_pkg::*;

    logic             valid;
    logic             ready;
    logic             req_type;
    logic [POS_W-1:0] pos_x;
    logic [POS_W-1:0] pos_y;
    logic [POS_W-1:0] pos_z;

    modport source (output valid, req_type, pos_x, pos_y, pos_z, input ready);
    modport sink   (input valid, req_type, pos_x, pos_y, pos_z, output ready);
endinterface

[sv/psv_resp_if.sv]
`timescale 1ns / 1ps
interface psv_resp_if;
    import psv_pkg::*;

    logic                    valid;
    logic                    ready;
    logic                    resp_kind;
    logic signed [OUT_W-1:0] voxel_value;

    modport source (output valid, resp_kind, voxel_value, input ready);
    modport sink   (input valid, resp_kind, voxel_value, output ready);
endinterface

[sv/psv_ram.sv]
`timescale 1ns / 1ps
module psv_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[sv/psv_cfg.sv]
`timescale 1ns / 1ps
module psv_cfg (
    input  logic              clk,
    input  logic              rst_n,
    psv_cfg_if.sink           cfg,
    output psv_pkg::psv_cfg_t settings
);
    import psv_pkg::*;

    logic [CFG_W-1:0]  dim_x_reg, dim_y_reg, dim_z_reg, radius_reg;
    logic [FILL_W-1:0] fill_reg;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dim_x_reg  <= CFG_W'(32);
            dim_y_reg  <= CFG_W'(32);
            dim_z_reg  <= CFG_W'(32);
            radius_reg <= CFG_W'(4);
            fill_reg   <= FILL_W'(4096);
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                CFG_DIM_X:  dim_x_reg  <= cfg.data[CFG_W-1:0];
                CFG_DIM_Y:  dim_y_reg  <= cfg.data[CFG_W-1:0];
                CFG_DIM_Z:  dim_z_reg  <= cfg.data[CFG_W-1:0];
                CFG_RADIUS: radius_reg <= cfg.data[CFG_W-1:0];
                CFG_FILL:   fill_reg   <= cfg.data[FILL_W-1:0];
                default:    ;
            endcase
        end
    end

    // out-of-range values folded into the usable range
    always_comb
    begin
        settings.dim_x  = clamp_dim(dim_x_reg);
        settings.dim_y  = clamp_dim(dim_y_reg);
        settings.dim_z  = clamp_dim(dim_z_reg);
        settings.radius = clamp_rad(radius_reg);
        settings.fill   = sat_fill($signed(fill_reg));
    end

endmodule

[sv/psv_seq.sv]
`timescale 1ns / 1ps
module psv_seq (
    input  logic                            clk,
    input  logic                            rst_n,
    input  psv_pkg::psv_cfg_t               settings,
    psv_req_if.sink                         req,
    psv_resp_if.source                      resp,
    output logic                            mem_we,
    output logic [psv_pkg::ADDR_W-1:0]      mem_waddr,
    output logic [psv_pkg::VALUE_BITS-1:0]  mem_wdata,
    output logic [psv_pkg::ADDR_W-1:0]      mem_raddr,
    input  logic [psv_pkg::VALUE_BITS-1:0]  mem_rdata
);
    import psv_pkg::*;

    psv_state_t state_reg, state_next;
    psv_axis_t  axis_reg, axis_next;

    logic [ADDR_W-1:0]        clr_addr_reg, clr_addr_next;
    logic                     is_read_reg, is_read_next;
    logic [POS_W-1:0]         pos_y_reg, pos_y_next, pos_z_reg, pos_z_next;
    logic signed [WRAP_W-1:0] wrap_reg, wrap_next;
    logic [SQ_W-1:0]          r2_reg, r2_next;

    logic [COORD_W-1:0] base_x_reg, base_x_next, base_y_reg, base_y_next;
    logic [COORD_W-1:0] base_z_reg, base_z_next;
    logic [COORD_W-1:0] cur_x_reg, cur_x_next, cur_y_reg, cur_y_next;
    logic [COORD_W-1:0] cur_z_reg, cur_z_next;
    logic [CNT_W-1:0]   cnt_x_reg, cnt_x_next, cnt_y_reg, cnt_y_next;
    logic [CNT_W-1:0]   cnt_z_reg, cnt_z_next;
    logic [SQ_W-1:0]    sq_x_reg, sq_x_next, sq_y_reg, sq_y_next, sq_z_reg, sq_z_next;

    logic                    resp_valid_reg, resp_valid_next;
    logic                    resp_kind_reg, resp_kind_next;
    logic signed [OUT_W-1:0] resp_value_reg, resp_value_next;

    logic                     accept;
    logic                     out_free;
    logic [DIM_W-1:0]         dim_sel;
    logic [POS_W-1:0]         pos_sel;
    logic [DIM_W-1:0]         roff;
    logic signed [WRAP_W-1:0] dim_s;
    logic                     wrap_lo, wrap_hi, wrap_ok;
    logic [CNT_W-1:0]         span;
    logic                     x_end, y_end, z_end;
    logic [SUM_W-1:0]         dist2;
    logic                     hit;

    // next squared offset: (d+1)^2 = d^2 + 2d + 1 with d = cnt - r
    function automatic logic [SQ_W-1:0] sq_step(
        input logic [SQ_W-1:0]  sq,
        input logic [CNT_W-1:0] cnt,
        input logic [DIM_W-1:0] r
    );
        logic signed [SQ_W+CNT_W+1:0] t;
        t = $signed((SQ_W+CNT_W+2)'(sq)) + $signed((SQ_W+CNT_W+2)'({cnt, 1'b0}))
            - $signed((SQ_W+CNT_W+2)'({r, 1'b0})) + (SQ_W+CNT_W+2)'(1);
        return SQ_W'(t);
    endfunction

    function automatic logic [COORD_W-1:0] inc_wrap(
        input logic [COORD_W-1:0] c,
        input logic [DIM_W-1:0]   d
    );
        if (c == COORD_W'(d - DIM_W'(1)))
            return '0;
        else
            return c + COORD_W'(1);
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            clr_addr_reg   <= '0;
            resp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            clr_addr_reg   <= clr_addr_next;
            resp_valid_reg <= resp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        axis_reg       <= axis_next;
        is_read_reg    <= is_read_next;
        pos_y_reg      <= pos_y_next;
        pos_z_reg      <= pos_z_next;
        wrap_reg       <= wrap_next;
        r2_reg         <= r2_next;
        base_x_reg     <= base_x_next;
        base_y_reg     <= base_y_next;
        base_z_reg     <= base_z_next;
        cur_x_reg      <= cur_x_next;
        cur_y_reg      <= cur_y_next;
        cur_z_reg      <= cur_z_next;
        cnt_x_reg      <= cnt_x_next;
        cnt_y_reg      <= cnt_y_next;
        cnt_z_reg      <= cnt_z_next;
        sq_x_reg       <= sq_x_next;
        sq_y_reg       <= sq_y_next;
        sq_z_reg       <= sq_z_next;
        resp_kind_reg  <= resp_kind_next;
        resp_value_reg <= resp_value_next;
    end

    // shared wrap unit: one add or subtract of the dimension per cycle
    always_comb
    begin
        case (axis_reg)
            AX_X:    begin dim_sel = settings.dim_x; pos_sel = pos_y_reg; end
            AX_Y:    begin dim_sel = settings.dim_y; pos_sel = pos_z_reg; end
            default: begin dim_sel = settings.dim_z; pos_sel = pos_z_reg; end
        endcase
        roff    = is_read_reg ? '0 : settings.radius;
        dim_s   = $signed(WRAP_W'(dim_sel));
        wrap_lo = wrap_reg < 0;
        wrap_hi = wrap_reg >= dim_s;
        wrap_ok = !wrap_lo && !wrap_hi;
    end

    // sweep counters and distance test
    always_comb
    begin
        span  = CNT_W'({settings.radius, 1'b0});
        x_end = cnt_x_reg == span;
        y_end = cnt_y_reg == span;
        z_end = cnt_z_reg == span;
        dist2 = SUM_W'(sq_x_reg) + SUM_W'(sq_y_reg) + SUM_W'(sq_z_reg);
        hit   = dist2 <= SUM_W'(r2_reg);
    end

    assign accept   = req.valid && req.ready;
    assign out_free = !resp_valid_reg || resp.ready;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
                if (clr_addr_reg == '1)
                    state_next = ST_IDLE;
            ST_IDLE:
                if (req.valid)
                    state_next = ST_WRAP;
            ST_WRAP:
                if (wrap_ok && axis_reg == AX_Z)
                    state_next = is_read_reg ? ST_READ : ST_SWEEP;
            ST_SWEEP:
                if (x_end && y_end && z_end)
                    state_next = ST_DONE;
            ST_READ:
                state_next = ST_DONE;
            ST_DONE:
                if (out_free)
                    state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    // outputs and datapath
    always_comb
    begin
        clr_addr_next   = clr_addr_reg;
        axis_next       = axis_reg;
        is_read_next    = is_read_reg;
        pos_y_next      = pos_y_reg;
        pos_z_next      = pos_z_reg;
        wrap_next       = wrap_reg;
        r2_next         = r2_reg;
        base_x_next     = base_x_reg;
        base_y_next     = base_y_reg;
        base_z_next     = base_z_reg;
        cur_x_next      = cur_x_reg;
        cur_y_next      = cur_y_reg;
        cur_z_next      = cur_z_reg;
        cnt_x_next      = cnt_x_reg;
        cnt_y_next      = cnt_y_reg;
        cnt_z_next      = cnt_z_reg;
        sq_x_next       = sq_x_reg;
        sq_y_next       = sq_y_reg;
        sq_z_next       = sq_z_reg;
        resp_valid_next = resp_valid_reg && !resp.ready;
        resp_kind_next  = resp_kind_reg;
        resp_value_next = resp_value_reg;
        req.ready       = 1'b0;
        mem_we          = 1'b0;
        mem_waddr       = {cur_z_reg, cur_y_reg, cur_x_reg};
        mem_wdata       = settings.fill;
        mem_raddr       = {base_z_reg, base_y_reg, base_x_reg};

        unique case (state_reg)
            ST_CLEAR:
            begin
                mem_we        = 1'b1;
                mem_waddr     = clr_addr_reg;
                mem_wdata     = '0;
                clr_addr_next = clr_addr_reg + ADDR_W'(1);
            end
            ST_IDLE:
            begin
                req.ready = 1'b1;
                if (accept)
                begin
                    is_read_next = req.req_type == REQ_READ;
                    pos_y_next   = req.pos_y;
                    pos_z_next   = req.pos_z;
                    axis_next    = AX_X;
                    r2_next      = SQ_W'(SQ_W'(settings.radius) * SQ_W'(settings.radius));
                    wrap_next    = $signed(WRAP_W'(req.pos_x)) - ((req.req_type == REQ_READ)
                                   ? '0 : $signed(WRAP_W'(settings.radius)));
                end
            end
            ST_WRAP:
            begin
                if (wrap_lo)
                    wrap_next = wrap_reg + dim_s;
                else if (wrap_hi)
                    wrap_next = wrap_reg - dim_s;
                else
                begin
                    case (axis_reg)
                        AX_X:
                        begin
                            base_x_next = wrap_reg[COORD_W-1:0];
                            cur_x_next  = wrap_reg[COORD_W-1:0];
                            axis_next   = AX_Y;
                        end
                        AX_Y:
                        begin
                            base_y_next = wrap_reg[COORD_W-1:0];
                            cur_y_next  = wrap_reg[COORD_W-1:0];
                            axis_next   = AX_Z;
                        end
                        default:
                        begin
                            base_z_next = wrap_reg[COORD_W-1:0];
                            cur_z_next  = wrap_reg[COORD_W-1:0];
                        end
                    endcase
                    wrap_next  = $signed(WRAP_W'(pos_sel)) - $signed(WRAP_W'(roff));
                    cnt_x_next = '0;
                    cnt_y_next = '0;
                    cnt_z_next = '0;
                    sq_x_next  = r2_reg;
                    sq_y_next  = r2_reg;
                    sq_z_next  = r2_reg;
                end
            end
            ST_SWEEP:
            begin
                mem_we = hit;
                if (x_end)
                begin
                    cnt_x_next = '0;
                    cur_x_next = base_x_reg;
                    sq_x_next  = r2_reg;
                    if (y_end)
                    begin
                        cnt_y_next = '0;
                        cur_y_next = base_y_reg;
                        sq_y_next  = r2_reg;
                        cnt_z_next = cnt_z_reg + CNT_W'(1);
                        cur_z_next = inc_wrap(cur_z_reg, settings.dim_z);
                        sq_z_next  = sq_step(sq_z_reg, cnt_z_reg, settings.radius);
                    end
                    else
                    begin
                        cnt_y_next = cnt_y_reg + CNT_W'(1);
                        cur_y_next = inc_wrap(cur_y_reg, settings.dim_y);
                        sq_y_next  = sq_step(sq_y_reg, cnt_y_reg, settings.radius);
                    end
                end
                else
                begin
                    cnt_x_next = cnt_x_reg + CNT_W'(1);
                    cur_x_next = inc_wrap(cur_x_reg, settings.dim_x);
                    sq_x_next  = sq_step(sq_x_reg, cnt_x_reg, settings.radius);
                end
            end
            ST_READ:
            begin
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    resp_valid_next = 1'b1;
                    resp_kind_next  = is_read_reg;
                    resp_value_next = is_read_reg ? widen(mem_rdata) : '0;
                end
            end
            default:
            begin
            end
        endcase
    end

    assign resp.valid       = resp_valid_reg;
    assign resp.resp_kind   = resp_kind_reg;
    assign resp.voxel_value = resp_value_reg;

endmodule

[sv/periodic_sphere_voxelizer.sv]
`timescale 1ns / 1ps
// periodic sphere voxelizer: keeps a 32x32x32 grid of 16-bit voxels in one
// single-port-write ram. after reset the grid is cleared by a sweep, one
// voxel a cycle, during which no request is taken (register writes are
// taken at any time). a place request covers every site within radius of
// the center with the fill value, wrapping each axis around the grid size
// in use; a read request returns one voxel. requests are handled one at a
// time by a small sequencer around one wrap adder and one distance test.
// each request is accepted, then per axis the start coordinate is folded
// by adding or subtracting the grid size as needed, then a place visits
// the (2*radius+1)^3 sites of its cube (729 at radius 4), writing those
// in the sphere, and a read waits on the registered ram read; then the
// response register is loaded once the previous response has gone. a new
// request is taken while the previous response still waits for its transfer.
module periodic_sphere_voxelizer (
    input logic         clk,
    input logic         rst_n,
    psv_cfg_if.sink     cfg,
    psv_req_if.sink     req,
    psv_resp_if.source  resp
);
    import psv_pkg::*;

    // effective register values after clamping
    psv_cfg_t settings;

    // ram ports driven by the sequencer
    logic                  mem_we;
    logic [ADDR_W-1:0]     mem_waddr;
    logic [VALUE_BITS-1:0] mem_wdata;
    logic [ADDR_W-1:0]     mem_raddr;
    logic [VALUE_BITS-1:0] mem_rdata;

    // configuration registers, always ready for a transfer
    psv_cfg u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .settings (settings)
    );

    // clearing sweep, coordinate folding and sphere sweep
    psv_seq u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .settings  (settings),
        .req       (req),
        .resp      (resp),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata),
        .mem_raddr (mem_raddr),
        .mem_rdata (mem_rdata)
    );

    // voxel grid, address is {z, y, x}
    psv_ram #(
        .WIDTH (VALUE_BITS),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

endmodule

[sv/psv_checker.sv]
`timescale 1ns / 1ps
`include "periodic_sphere_voxelizer_defines.svh"
module psv_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           req_valid,
    input logic                           req_ready,
    input logic                           resp_valid,
    input logic                           resp_ready,
    input logic                           resp_kind,
    input logic signed [psv_pkg::OUT_W-1:0] resp_voxel_value
);
    import psv_pkg::*;

    `PSV_ASSERT_NXT(a_resp_hold, clk, rst_n, resp_valid && !resp_ready, resp_valid)
    `PSV_ASSERT_NXT(a_resp_stable, clk, rst_n, resp_valid && !resp_ready, $stable(resp_kind) && $stable(resp_voxel_value))
    `PSV_ASSERT_IMP(a_place_zero, clk, rst_n, resp_valid && (resp_kind == REQ_PLACE), resp_voxel_value == '0)
    `PSV_ASSERT_NXT(a_busy_after_req, clk, rst_n, req_valid && req_ready, !req_ready)

endmodule

bind periodic_sphere_voxelizer psv_checker u_psv_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .req_valid        (req.valid),
    .req_ready        (req.ready),
    .resp_valid       (resp.valid),
    .resp_ready       (resp.ready),
    .resp_kind        (resp.resp_kind),
    .resp_voxel_value (resp.voxel_value)
);
